@@ hw/rtl/olpt_pkg.sv @@
// Package for the output latch pulse timer: request codes, sizes and the
// control structures passed between the top level and the channel lanes.
// No dependencies.
package olpt_pkg;

  // Number of output channels and the width of each channel's tick counter.
  localparam int CHANNELS  = 16;
  localparam int TICK_BITS = 16;

  // The output word is fixed at sixteen bits, so at most sixteen lanes exist.
  localparam int WORD_W = 16;
  localparam int LANES  = (CHANNELS < WORD_W) ? CHANNELS : WORD_W;
  localparam int CH_W   = 4;
  localparam int DUR_W  = 16;
  // Compare width wide enough for both the counter and the duration.
  localparam int CMP_W  = (TICK_BITS > DUR_W) ? TICK_BITS : DUR_W;

  typedef enum logic [1:0] {
    REQ_SET   = 2'd0,
    REQ_WORD  = 2'd1,
    REQ_PULSE = 2'd2,
    REQ_TICK  = 2'd3
  } olpt_req_e;

  // Command from the top level to one lane for the word being retired.
  typedef struct packed {
    logic              start_pulse;
    logic              tick;
    logic              level;
    logic [DUR_W-1:0]  duration;
    logic              cur_bit;
  } olpt_lane_cmd_t;

  // Response of one lane.
  typedef struct packed {
    logic drive_en;
    logic drive_val;
    logic active_q;
    logic active_d;
  } olpt_lane_rsp_t;

endpackage

@@ hw/rtl/output_latch_pulse_timer.sv @@
// Top level of the sixteen-channel output latch with timed pulses.
// Depends on olpt_pkg and olpt_lane.
//
//  channel  | direction | tuser          | tdata (lowest bit up)
//  ---------+-----------+----------------+------------------------------------
//  s_axis   | in        | req_type [1:0] | channel, level, duration_ms,
//           |           |                | word_value, zero pad to 40 bits
//  m_axis   | out       | none           | output_word, pulse_mask
//
// Every word passes through the input register and then the result
// register, and one word is accepted per cycle while m_axis_tready is high.
// The rate is set by the single pass through the lane logic, where all
// channels update in parallel on a tick.
// Reset clears the output word, every lane and both valid flags at once.
// When the result register is held by a low m_axis_tready, the input
// register keeps its word and s_axis_tready drops only once both are full.
module output_latch_pulse_timer (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [39:0] s_axis_tdata,   // channel, level, duration_ms, word_value, pad
  input  logic [1:0]  s_axis_tuser,   // req_type
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [31:0] m_axis_tdata    // output_word, pulse_mask
);
  import olpt_pkg::*;

  // Input register holding the word being worked on.
  logic             in_valid_q, in_valid_d;
  olpt_req_e        in_req_q;
  logic [CH_W-1:0]  in_ch_q;
  logic             in_lvl_q;
  logic [DUR_W-1:0] in_dur_q;
  logic [WORD_W-1:0] in_word_q;

  // Result register and the latched output word.
  logic              out_valid_q, out_valid_d;
  logic [WORD_W-1:0] out_word_q;
  logic [WORD_W-1:0] out_mask_q;
  logic [WORD_W-1:0] out_bits_q, out_bits_d;
  logic [WORD_W-1:0] base_bits;
  logic [WORD_W-1:0] mask_d;
  logic [WORD_W-1:0] mask_now;

  logic s_fire;
  logic advance;
  logic ch_ok;

  olpt_lane_cmd_t lane_cmd [LANES];
  olpt_lane_rsp_t lane_rsp [LANES];

  // The working word retires when the result register is free or draining.
  assign advance       = in_valid_q && (!out_valid_q || m_axis_tready);
  assign s_axis_tready = !in_valid_q || advance;
  assign s_fire        = s_axis_tvalid && s_axis_tready;
  assign in_valid_d    = s_fire ? 1'b1 : (advance ? 1'b0 : in_valid_q);
  assign out_valid_d   = advance ? 1'b1 : (m_axis_tready ? 1'b0 : out_valid_q);

  // Requests that name a channel without a lane are ignored.
  assign ch_ok = ({1'b0, in_ch_q} < (CH_W + 1)'(LANES));

  // Effect of set and whole-word writes before any lane overrides its bit.
  always_comb begin
    base_bits = out_bits_q;
    case (in_req_q)
      REQ_SET: begin
        if (ch_ok) begin
          base_bits[in_ch_q] = in_lvl_q;
        end
      end
      REQ_WORD: begin
        base_bits = in_word_q;
      end
      default: begin
        base_bits = out_bits_q;
      end
    endcase
  end

  for (genvar i = 0; i < LANES; i++) begin : g_lane
    assign lane_cmd[i].start_pulse = advance && (in_req_q == REQ_PULSE) && ch_ok &&
                                     (in_ch_q == CH_W'(i));
    assign lane_cmd[i].tick        = advance && (in_req_q == REQ_TICK);
    assign lane_cmd[i].level       = in_lvl_q;
    assign lane_cmd[i].duration    = in_dur_q;
    assign lane_cmd[i].cur_bit     = out_bits_q[i];

    olpt_lane u_lane (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .cmd_i  (lane_cmd[i]),
      .rsp_o  (lane_rsp[i])
    );
  end

  // A lane that drives its bit (pulse start, tick refresh or restore)
  // takes priority over the plain request effect.
  always_comb begin
    out_bits_d = base_bits;
    mask_d     = '0;
    mask_now   = '0;
    for (int c = 0; c < LANES; c++) begin
      if (lane_rsp[c].drive_en) begin
        out_bits_d[c] = lane_rsp[c].drive_val;
      end
      mask_d[c]   = lane_rsp[c].active_d;
      mask_now[c] = lane_rsp[c].active_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
      out_bits_q  <= '0;
    end else begin
      in_valid_q  <= in_valid_d;
      out_valid_q <= out_valid_d;
      if (advance) begin
        out_bits_q <= out_bits_d;
      end
    end
  end

  // Payload registers carry no reset.
  always_ff @(posedge clk_i) begin
    if (s_fire) begin
      in_req_q  <= olpt_req_e'(s_axis_tuser);
      in_ch_q   <= s_axis_tdata[3:0];
      in_lvl_q  <= s_axis_tdata[4];
      in_dur_q  <= s_axis_tdata[20:5];
      in_word_q <= s_axis_tdata[36:21];
    end
    if (advance) begin
      out_word_q <= out_bits_d;
      out_mask_q <= mask_d;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {out_mask_q, out_word_q};

`ifndef ASSERT_OFF
  // The input side stalls only when both registers are full and blocked.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !s_axis_tready |-> (in_valid_q && out_valid_q && !m_axis_tready))
    else $error("input stalled without a full pipeline");

  // A retired word always lands in the result register.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    advance |=> m_axis_tvalid)
    else $error("retired word did not reach the result register");

  // A word that cannot retire stays in the input register unchanged.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_q && !advance) |=> (in_valid_q && $stable(in_dur_q) && $stable(in_ch_q)))
    else $error("working word lost while stalled");

  // The reported pulse mask always matches the lanes' live state.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q |-> (out_mask_q == mask_now))
    else $error("pulse mask out of step with the lanes");

  // The output word in the result register is the latched word.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q |-> (out_word_q == out_bits_q))
    else $error("reported output word differs from the latch");
`endif

endmodule

@@ hw/rtl/olpt_lane.sv @@
// One pulse channel: holds the pulse level, restore level, length and tick
// counter, and decides what the channel's output bit becomes.
// Depends on olpt_pkg.
module olpt_lane (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  olpt_pkg::olpt_lane_cmd_t cmd_i,
  output olpt_pkg::olpt_lane_rsp_t rsp_o
);
  import olpt_pkg::*;

  logic [DUR_W-1:0]     len_q, len_d;
  logic [TICK_BITS-1:0] elapsed_q, elapsed_d, elapsed_inc;
  logic                 plvl_q, plvl_d;
  logic                 rlvl_q, rlvl_d;
  logic                 armed_q, armed_d;
  logic                 active;

  assign active      = (len_q != '0);
  // The counter stops at its maximum, so a pulse of the maximum duration never ends.
  assign elapsed_inc = (elapsed_q == '1) ? elapsed_q : elapsed_q + TICK_BITS'(1);

  always_comb begin
    len_d           = len_q;
    elapsed_d       = elapsed_q;
    plvl_d          = plvl_q;
    rlvl_d          = rlvl_q;
    armed_d         = armed_q;
    rsp_o.drive_en  = 1'b0;
    rsp_o.drive_val = 1'b0;
    if (cmd_i.start_pulse) begin
      rlvl_d          = cmd_i.cur_bit;
      plvl_d          = cmd_i.level;
      len_d           = cmd_i.duration;
      armed_d         = 1'b0;
      elapsed_d       = '0;
      rsp_o.drive_en  = 1'b1;
      rsp_o.drive_val = cmd_i.level;
    end else if (cmd_i.tick && active) begin
      rsp_o.drive_en  = 1'b1;
      rsp_o.drive_val = plvl_q;
      if (!armed_q) begin
        armed_d   = 1'b1;
        elapsed_d = '0;
      end else if (CMP_W'(elapsed_inc) > CMP_W'(len_q)) begin
        rsp_o.drive_val = rlvl_q;
        len_d           = '0;
        elapsed_d       = '0;
        plvl_d          = 1'b0;
        rlvl_d          = 1'b0;
        armed_d         = 1'b0;
      end else begin
        elapsed_d = elapsed_inc;
      end
    end
    rsp_o.active_q = active;
    rsp_o.active_d = (len_d != '0);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      len_q     <= '0;
      elapsed_q <= '0;
      plvl_q    <= 1'b0;
      rlvl_q    <= 1'b0;
      armed_q   <= 1'b0;
    end else begin
      len_q     <= len_d;
      elapsed_q <= elapsed_d;
      plvl_q    <= plvl_d;
      rlvl_q    <= rlvl_d;
      armed_q   <= armed_d;
    end
  end

endmodule
